// File: hw/rtl/sattr_pkg.sv
// shared types and codes for the sat assignment trail
// no dependencies; imported by the trail top level and its checker
package sattr_pkg;

    localparam int LIT_W    = 12;
    localparam int REASON_W = 16;
    localparam int HEAD_W   = 11;
    localparam int COUNT_W  = 11;

    typedef enum logic [1:0] {
        ACT_DECIDE   = 2'd0,
        ACT_IMPLY    = 2'd1,
        ACT_POP      = 2'd2,
        ACT_SET_HEAD = 2'd3
    } action_t;

    typedef enum logic [1:0] {
        ERR_OK      = 2'd0,
        ERR_LITERAL = 2'd1,
        ERR_EMPTY   = 2'd2
    } error_t;

    localparam logic [1:0] VAL_UNDEF = 2'd0;
    localparam logic [1:0] VAL_TRUE  = 2'd1;
    localparam logic [1:0] VAL_FALSE = 2'd2;

    localparam logic [1:0] PH_FALSE   = 2'b00;
    localparam logic [1:0] PH_TRUE    = 2'b01;
    localparam logic [1:0] PH_UNKNOWN = 2'b11;

    typedef enum logic [1:0] {
        S_CLEAR = 2'd0,
        S_IDLE  = 2'd1,
        S_EXEC  = 2'd2
    } state_t;

    // output tdata bit positions, lowest field first
    localparam int OUT_POP_LO   = 0;
    localparam int OUT_LVL_LO   = OUT_POP_LO + LIT_W;
    localparam int OUT_SIZE_LO  = OUT_LVL_LO + COUNT_W;
    localparam int OUT_HEAD_LO  = OUT_SIZE_LO + COUNT_W;
    localparam int OUT_PRIOR_LO = OUT_HEAD_LO + HEAD_W;
    localparam int OUT_ERR_LO   = OUT_PRIOR_LO + 2;
    localparam int OUT_W        = 56;
    localparam int IN_W         = 40;

endpackage

// File: hw/rtl/sat_assignment_trail_top.sv
// assignment trail of a cdcl sat solver: per-variable table and trail stack in memories
// depends on sattr_pkg
//
// Each request is accepted, then executed: the accept cycle issues the reads of the
// variable table (at the request literal) and of the trail (at the entry below the top),
// and the execute cycle checks, writes both memories and loads the result register. The
// next request is taken in the cycle after that, so a new read always sees the previous
// write; both memories are read through registers. After reset the variable table is
// swept once, with s_tready low, before the first request is taken.
// A finished result waits in an output register; the next request may be accepted
// meanwhile and only its execute cycle stalls until that register is free.
module sat_assignment_trail_top #(
    parameter int MAX_VARS    = 1024,
    parameter int REASON_BITS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    // literal[11:0], reason_index[27:12], head_value[38:28], zero fill
    input  logic [sattr_pkg::IN_W-1:0]   s_tdata,
    // action[1:0]
    input  logic [1:0]                   s_tuser,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    // popped_literal[11:0], level[22:12], trail_size[33:23], prop_head[44:34],
    // prior_value[46:45], error[48:47], zero fill
    output logic [sattr_pkg::OUT_W-1:0]  m_tdata
);
    import sattr_pkg::*;

    localparam int AW = (MAX_VARS > 1) ? $clog2(MAX_VARS) : 1;
    localparam int CW = $clog2(MAX_VARS + 1);

    typedef struct packed {
        logic signed [AW:0] pos;
        logic [1:0]         phase;
        logic [1:0]         value;
    } var_word_t;

    typedef struct packed {
        logic signed [LIT_W-1:0] lit;
        logic [CW-1:0]           lvl;
        logic [REASON_BITS-1:0]  reason;
    } trail_word_t;

    var_word_t   var_mem   [MAX_VARS];
    trail_word_t trail_mem [MAX_VARS];

    state_t                   state_reg, state_next;
    logic [AW-1:0]            clr_reg, clr_next;
    logic [CW-1:0]            count_reg, count_next;
    logic [CW-1:0]            level_reg, level_next;
    logic signed [HEAD_W-1:0] head_reg, head_next;
    logic signed [LIT_W-1:0]  top_lit_reg, top_lit_next;
    action_t                  act_reg, act_next;
    logic signed [LIT_W-1:0]  lit_reg, lit_next;
    logic [REASON_W-1:0]      reason_reg, reason_next;
    logic signed [HEAD_W-1:0] head_in_reg, head_in_next;
    logic                     out_valid_reg, out_valid_next;
    logic [OUT_W-1:0]         out_data_reg, out_data_next;

    var_word_t                var_rd_reg;
    trail_word_t              tr_rd_reg;

    logic                     accept;
    logic [AW-1:0]            in_addr;
    logic [AW-1:0]            tr_raddr;
    logic                     var_we;
    logic [AW-1:0]            var_waddr;
    var_word_t                var_wdata;
    logic                     tr_we;
    logic [AW-1:0]            tr_waddr;
    trail_word_t              tr_wdata;

    logic [LIT_W:0]           lit_mag;
    logic [LIT_W:0]           top_mag;
    logic [LIT_W:0]           in_mag;
    logic                     lit_ok;
    logic                     can_push;
    logic [1:0]               prior;
    error_t                   err;
    logic signed [LIT_W-1:0]  popped;

    assign s_tready = (state_reg == S_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    assign in_mag   = s_tdata[LIT_W-1] ? (LIT_W+1)'(-$signed(s_tdata[LIT_W-1:0]))
                                       : (LIT_W+1)'(s_tdata[LIT_W-1:0]);
    assign in_addr  = AW'(int'(in_mag) - 1);
    // entry below the top holds the level after a pop
    assign tr_raddr = AW'(int'(count_reg) - 2);

    assign lit_mag  = lit_reg[LIT_W-1] ? (LIT_W+1)'(-lit_reg) : (LIT_W+1)'(lit_reg);
    assign top_mag  = top_lit_reg[LIT_W-1] ? (LIT_W+1)'(-top_lit_reg)
                                           : (LIT_W+1)'(top_lit_reg);
    assign lit_ok   = (lit_mag != '0) && (int'(lit_mag) <= MAX_VARS);
    assign prior    = lit_ok ? var_rd_reg.value : VAL_UNDEF;
    assign can_push = lit_ok && (var_rd_reg.value == VAL_UNDEF) && (int'(count_reg) < MAX_VARS);

    always_ff @(posedge clk)
    begin
        if (var_we)
        begin
            var_mem[var_waddr] <= var_wdata;
        end
        if (tr_we)
        begin
            trail_mem[tr_waddr] <= tr_wdata;
        end
        if (accept)
        begin
            var_rd_reg <= var_mem[in_addr];
            tr_rd_reg  <= trail_mem[tr_raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            count_reg     <= '0;
            level_reg     <= '0;
            head_reg      <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            count_reg     <= count_next;
            level_reg     <= level_next;
            head_reg      <= head_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        top_lit_reg  <= top_lit_next;
        act_reg      <= act_next;
        lit_reg      <= lit_next;
        reason_reg   <= reason_next;
        head_in_reg  <= head_in_next;
        out_data_reg <= out_data_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        clr_next       = clr_reg;
        count_next     = count_reg;
        level_next     = level_reg;
        head_next      = head_reg;
        top_lit_next   = top_lit_reg;
        act_next       = act_reg;
        lit_next       = lit_reg;
        reason_next    = reason_reg;
        head_in_next   = head_in_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        var_we         = 1'b0;
        var_waddr      = clr_reg;
        var_wdata      = '{pos: '1, phase: PH_UNKNOWN, value: VAL_UNDEF};
        tr_we          = 1'b0;
        tr_waddr       = AW'(count_reg);
        tr_wdata       = '{lit: lit_reg, lvl: level_reg, reason: REASON_BITS'(reason_reg)};
        err            = ERR_OK;
        popped         = '0;

        case (state_reg)
            S_CLEAR:
            begin
                var_we = 1'b1;
                if (clr_reg == AW'(MAX_VARS - 1))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + 1'b1;
                end
            end
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next   = S_EXEC;
                    act_next     = action_t'(s_tuser);
                    lit_next     = s_tdata[LIT_W-1:0];
                    reason_next  = s_tdata[LIT_W+REASON_W-1:LIT_W];
                    head_in_next = s_tdata[LIT_W+REASON_W+HEAD_W-1:LIT_W+REASON_W];
                end
            end
            S_EXEC:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    case (act_reg)
                        ACT_DECIDE, ACT_IMPLY:
                        begin
                            if (can_push)
                            begin
                                var_we          = 1'b1;
                                var_waddr       = AW'(int'(lit_mag) - 1);
                                var_wdata.pos   = (AW+1)'(count_reg);
                                var_wdata.phase = var_rd_reg.phase;
                                var_wdata.value = lit_reg[LIT_W-1] ? VAL_FALSE : VAL_TRUE;
                                tr_we           = 1'b1;
                                if (act_reg == ACT_DECIDE)
                                begin
                                    tr_wdata.lvl    = level_reg + 1'b1;
                                    tr_wdata.reason = '0;
                                    level_next      = level_reg + 1'b1;
                                end
                                count_next   = count_reg + 1'b1;
                                top_lit_next = lit_reg;
                            end
                            else
                            begin
                                err = ERR_LITERAL;
                            end
                        end
                        ACT_POP:
                        begin
                            if (count_reg == '0)
                            begin
                                err = ERR_EMPTY;
                            end
                            else
                            begin
                                // popped variable is assigned, so its phase is its sign
                                popped          = top_lit_reg;
                                var_we          = 1'b1;
                                var_waddr       = AW'(int'(top_mag) - 1);
                                var_wdata.pos   = '1;
                                var_wdata.phase = top_lit_reg[LIT_W-1] ? PH_FALSE : PH_TRUE;
                                var_wdata.value = VAL_UNDEF;
                                count_next      = count_reg - 1'b1;
                                top_lit_next    = tr_rd_reg.lit;
                                level_next      = (count_reg == CW'(1)) ? '0 : tr_rd_reg.lvl;
                                if (int'(head_reg) > int'(count_reg) - 2)
                                begin
                                    head_next = HEAD_W'(int'(count_reg) - 2);
                                end
                            end
                        end
                        default:
                        begin
                            head_next = head_in_reg;
                        end
                    endcase
                    out_valid_next = 1'b1;
                    out_data_next  = '0;
                    out_data_next[OUT_POP_LO +: LIT_W]     = popped;
                    out_data_next[OUT_LVL_LO +: COUNT_W]   = COUNT_W'(level_next);
                    out_data_next[OUT_SIZE_LO +: COUNT_W]  = COUNT_W'(count_next);
                    out_data_next[OUT_HEAD_LO +: HEAD_W]   = head_next;
                    out_data_next[OUT_PRIOR_LO +: 2]       = prior;
                    out_data_next[OUT_ERR_LO +: 2]         = err;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// File: hw/rtl/sattr_checker.sv
// port-level checks for the sat assignment trail, bound to the top level
// depends on sattr_pkg and sat_assignment_trail_top
module sattr_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [sattr_pkg::OUT_W-1:0] m_tdata
);
    import sattr_pkg::*;

    logic [COUNT_W-1:0] o_level;
    logic [COUNT_W-1:0] o_size;
    logic [LIT_W-1:0]   o_popped;
    logic [1:0]         o_err;

    assign o_level  = m_tdata[OUT_LVL_LO +: COUNT_W];
    assign o_size   = m_tdata[OUT_SIZE_LO +: COUNT_W];
    assign o_popped = m_tdata[OUT_POP_LO +: LIT_W];
    assign o_err    = m_tdata[OUT_ERR_LO +: 2];

    // a waiting result holds its value
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // one request at a time, each needs an execute cycle
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while previous one in flight");

    // a failed pop only happens on an empty trail and pops nothing
    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && o_err == ERR_EMPTY |-> o_size == '0 && o_popped == '0 && o_level == '0)
        else $error("empty pop result inconsistent");

    // every decision level owns at least one trail entry
    a_level_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> o_level <= o_size)
        else $error("level exceeds trail size");

endmodule

bind sat_assignment_trail_top sattr_checker u_sattr_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// File: sim/sattr_trail_checker.sv
// request/result scoreboard for the sat assignment trail: predicts every result
// from the accepted requests and compares it with what the block returns
// depends on sattr_pkg
module sattr_trail_checker #(
    parameter int MAX_VARS = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    input  logic                          s_tready,
    // literal[11:0], reason_index[27:12], head_value[38:28], zero fill
    input  logic [sattr_pkg::IN_W-1:0]    s_tdata,
    // action[1:0]
    input  logic [1:0]                    s_tuser,
    input  logic                          m_tvalid,
    input  logic                          m_tready,
    // popped_literal[11:0], level[22:12], trail_size[33:23], prop_head[44:34],
    // prior_value[46:45], error[48:47], zero fill
    input  logic [sattr_pkg::OUT_W-1:0]   m_tdata,
    output int                            fail_count,
    output int                            pending,
    output int                            checked,
    output int                            deepest
);
    timeunit 1ns;
    timeprecision 1ps;

    import sattr_pkg::*;

    typedef struct packed {
        logic signed [LIT_W-1:0]   popped;
        logic [COUNT_W-1:0]        level;
        logic [COUNT_W-1:0]        size;
        logic signed [HEAD_W-1:0]  head;
        logic [1:0]                prior;
        error_t                    err;
    } trail_result_t;

    trail_result_t           expected_q[$];
    logic [1:0]              var_value [0:MAX_VARS];
    logic signed [LIT_W-1:0] trail_lit [0:MAX_VARS-1];
    int                      trail_lvl [0:MAX_VARS-1];
    int                      trail_depth;
    int                      cur_level;
    int                      prop_head;

    function automatic trail_result_t step_trail(action_t act, logic signed [LIT_W-1:0] lit,
                                                 logic signed [HEAD_W-1:0] head_in);
        trail_result_t r;
        int            l;
        int            mag;
        int            v;
        l   = lit;
        mag = (l < 0) ? -l : l;
        r   = '0;
        r.err = ERR_OK;
        if (mag >= 1 && mag <= MAX_VARS)
            r.prior = var_value[mag];
        case (act)
            ACT_DECIDE, ACT_IMPLY:
            begin
                if (mag < 1 || mag > MAX_VARS || var_value[mag] != VAL_UNDEF
                    || trail_depth >= MAX_VARS)
                    r.err = ERR_LITERAL;
                else
                begin
                    if (act == ACT_DECIDE)
                        cur_level++;
                    trail_lit[trail_depth] = lit;
                    trail_lvl[trail_depth] = cur_level;
                    var_value[mag] = (l > 0) ? VAL_TRUE : VAL_FALSE;
                    trail_depth++;
                end
            end
            ACT_POP:
            begin
                if (trail_depth == 0)
                    r.err = ERR_EMPTY;
                else
                begin
                    r.popped = trail_lit[trail_depth-1];
                    v = r.popped;
                    v = (v < 0) ? -v : v;
                    var_value[v] = VAL_UNDEF;
                    trail_depth--;
                    cur_level = (trail_depth == 0) ? 0 : trail_lvl[trail_depth-1];
                    // head never points past the new top entry
                    if (prop_head > trail_depth - 1)
                        prop_head = trail_depth - 1;
                end
            end
            default:
                prop_head = head_in;
        endcase
        r.level = COUNT_W'(cur_level);
        r.size  = COUNT_W'(trail_depth);
        r.head  = HEAD_W'(prop_head);
        return r;
    endfunction

    function automatic void check_field(string name, int want, int got);
        if (want != got)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        trail_result_t want;
        if (!rst_n)
        begin
            expected_q.delete();
            for (int i = 0; i <= MAX_VARS; i++)
                var_value[i] = VAL_UNDEF;
            trail_depth = 0;
            cur_level   = 0;
            prop_head   = -1;
            fail_count  = 0;
            pending     = 0;
            checked     = 0;
            deepest     = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_q.size() == 0)
                begin
                    $error("result with no request outstanding: %h", m_tdata);
                    fail_count++;
                end
                else
                begin
                    want = expected_q.pop_front();
                    check_field("popped_literal", want.popped,
                                $signed(m_tdata[OUT_POP_LO +: LIT_W]));
                    check_field("level", want.level, m_tdata[OUT_LVL_LO +: COUNT_W]);
                    check_field("trail_size", want.size, m_tdata[OUT_SIZE_LO +: COUNT_W]);
                    check_field("prop_head", want.head,
                                $signed(m_tdata[OUT_HEAD_LO +: HEAD_W]));
                    check_field("prior_value", want.prior, m_tdata[OUT_PRIOR_LO +: 2]);
                    check_field("error", want.err, m_tdata[OUT_ERR_LO +: 2]);
                    checked++;
                end
            end
            if (s_tvalid && s_tready)
            begin
                expected_q.insert(expected_q.size(),
                                  step_trail(action_t'(s_tuser), s_tdata[11:0],
                                             s_tdata[38:28]));
                if (trail_depth > deepest)
                    deepest = trail_depth;
            end
            pending = expected_q.size();
        end
    end

endmodule

// File: sim/tb_sat_assignment_trail_top.sv
// testbench top for the sat assignment trail: clock, reset, request stimulus,
// output stalls and the verdict; depends on sattr_pkg, the trail rtl and sattr_trail_checker
module tb_sat_assignment_trail_top;
    timeunit 1ns;
    timeprecision 1ps;

    import sattr_pkg::*;

    localparam int MAX_VARS       = 1024;
    localparam int RANDOM_ITEMS   = 1030;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int HOLD_AT        = 620;
    localparam int HOLD_CYCLES    = 150;
    localparam int CALM_FROM      = 400;
    localparam int CALM_TO        = 560;

    logic              clk = 1'b0;
    logic              rst_n;
    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;
    logic [1:0]        s_tuser;
    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    int chk_fails;
    int chk_pending;
    int chk_checked;
    int chk_deepest;
    int sent_count = 0;
    int stall_cycles = 0;

    // variables the sender believes assigned, used only to steer the stimulus
    bit assigned_var [1:MAX_VARS];
    int var_stack[$];

    always #1 clk = ~clk;

    sat_assignment_trail_top #(
        .MAX_VARS    (MAX_VARS),
        .REASON_BITS (16)
    ) i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    sattr_trail_checker #(
        .MAX_VARS (MAX_VARS)
    ) i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .fail_count (chk_fails),
        .pending    (chk_pending),
        .checked    (chk_checked),
        .deepest    (chk_deepest)
    );

    function automatic bit calm();
        return sent_count >= CALM_FROM && sent_count < CALM_TO;
    endfunction

    function automatic int signed_pick(int v);
        return $urandom_range(0, 1) ? v : -v;
    endfunction

    // entered and left at a falling edge; valid is high on exit and may drop for a random gap before the next request
    task automatic send_request(action_t act, int lit, int reason, int hv);
        int mag;
        if (!calm() && $urandom_range(0, 99) < 22)
        begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tuser  = act;
        s_tdata  = {1'b0, 11'(hv), 16'(reason), 12'(lit)};
        do
            @(posedge clk);
        while (!s_tready);
        @(negedge clk);
        sent_count++;
        mag = (lit < 0) ? -lit : lit;
        if ((act == ACT_DECIDE || act == ACT_IMPLY) && mag >= 1 && mag <= MAX_VARS
            && !assigned_var[mag])
        begin
            assigned_var[mag] = 1'b1;
            var_stack.insert(var_stack.size(), mag);
        end
        else if (act == ACT_POP && var_stack.size() > 0)
        begin
            assigned_var[var_stack[$]] = 1'b0;
            var_stack.delete(var_stack.size() - 1);
        end
    endtask

    initial
    begin : stimulus
        action_t act;
        int      lit;
        int      reason;
        int      hv;
        int      r;
        int      v;
        int      seg_left;
        bit      growing;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        s_tuser  = ACT_DECIDE;
        rst_n    = 1'b0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: rejects, extremes, head clamping on the way back down
        send_request(ACT_POP,      2047,     16'h0000, 0);
        send_request(ACT_DECIDE,   0,        16'h1234, 0);
        send_request(ACT_IMPLY,    1025,     16'hFFFF, 0);
        send_request(ACT_DECIDE,   -2048,    16'h0000, -1024);
        send_request(ACT_DECIDE,   1,        16'h0000, 0);
        send_request(ACT_IMPLY,    -1024,    16'hFFFF, 1023);
        send_request(ACT_IMPLY,    1,        16'h0001, 0);
        send_request(ACT_DECIDE,   -1024,    16'h0000, 0);
        send_request(ACT_DECIDE,   512,      16'hFFFF, 0);
        send_request(ACT_IMPLY,    -2,       16'h0000, 0);
        send_request(ACT_SET_HEAD, -1024,    16'h0000, 1023);
        send_request(ACT_SET_HEAD, 0,        16'hFFFF, -1024);
        send_request(ACT_SET_HEAD, 2,        16'h0000, -1);
        send_request(ACT_SET_HEAD, -2048,    16'h0000, 3);
        send_request(ACT_POP,      2047,     16'h0000, 0);
        send_request(ACT_POP,      512,      16'hFFFF, 1023);
        send_request(ACT_POP,      -1024,    16'h0000, 0);
        send_request(ACT_POP,      1,        16'h0000, 0);
        send_request(ACT_POP,      -1,       16'h0000, 0);
        send_request(ACT_IMPLY,    7,        16'h5A5A, 0);
        send_request(ACT_SET_HEAD, 7,        16'h0000, 0);
        send_request(ACT_POP,      7,        16'hA5A5, 0);

        growing  = 1'b0;
        seg_left = 0;
        for (int n = 0; n < RANDOM_ITEMS; n++)
        begin
            if (seg_left == 0)
            begin
                growing  = !growing;
                seg_left = $urandom_range(40, 250);
            end
            seg_left--;
            r      = $urandom_range(0, 99);
            reason = $urandom_range(0, 65535);
            hv     = int'($urandom_range(0, 2047)) - 1024;
            lit    = int'($urandom_range(0, 4095)) - 2048;
            if (var_stack.size() >= MAX_VARS)
                r = 80;
            if (r < (growing ? 70 : 25))
            begin
                act = (r < (growing ? 25 : 10)) ? ACT_DECIDE : ACT_IMPLY;
                v = ($urandom_range(0, 9) == 0) ? ($urandom_range(0, 1) ? 1 : MAX_VARS)
                                                : int'($urandom_range(1, MAX_VARS));
                while (assigned_var[v])
                    v = $urandom_range(1, MAX_VARS);
                lit = signed_pick(v);
            end
            else if (r < 93)
            begin
                act = (r < 85) ? ACT_POP : ACT_SET_HEAD;
                if (act == ACT_SET_HEAD && $urandom_range(0, 9) < 7)
                    hv = int'($urandom_range(0, var_stack.size())) - 1;
                // prior_value is reported for these too, so name live variables often
                if (var_stack.size() > 0 && $urandom_range(0, 9) < 4)
                    lit = signed_pick(var_stack[$urandom_range(0, var_stack.size() - 1)]);
            end
            else
            begin
                act = $urandom_range(0, 1) ? ACT_DECIDE : ACT_IMPLY;
                if (var_stack.size() > 0 && $urandom_range(0, 1))
                    lit = signed_pick(var_stack[$urandom_range(0, var_stack.size() - 1)]);
                else
                    case ($urandom_range(0, 2))
                        0:       lit = 0;
                        1:       lit = -2048;
                        default: lit = signed_pick($urandom_range(MAX_VARS + 1, 2047));
                    endcase
            end
            send_request(act, lit, reason, hv);
        end
        s_tvalid = 1'b0;

        while (chk_pending != 0)
            @(negedge clk);
        repeat (10) @(negedge clk);
        $display("trail run: %0d requests sent, %0d results compared, deepest trail %0d",
                 sent_count, chk_checked, chk_deepest);
        $display("decide, imply, pop and set-head mixed with rejects and a %0d cycle stall",
                 HOLD_CYCLES);
        if (chk_fails == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin : receiver
        bit held;
        held     = 1'b0;
        m_tready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (!held && sent_count >= HOLD_AT)
            begin
                // long hold-off so the block backs up into its input
                held     = 1'b1;
                m_tready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end
            else if (calm())
                m_tready = 1'b1;
            else
                m_tready = ($urandom_range(0, 99) >= 22);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Test completed with failures");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

endmodule
